### hw/rtl/bzr_pkg.sv
// Shared types and constants for the quadratic Bezier point generator.
`timescale 1ns / 1ps
package bzr_pkg;

	localparam int MAX_POINTS = 64;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = 7;
	localparam int CRD_W      = 16;
	localparam int T_W        = 17;
	localparam int IN_W       = 104;
	localparam int OUT_W      = 40;

	typedef enum logic {
		SEQ_IDLE,
		SEQ_RUN
	} seq_state_t;

	// One point request from the sequencer into the arithmetic pipeline.
	typedef struct packed {
		logic [T_W-1:0]          t;
		logic [IDX_W-1:0]        idx;
		logic                    last;
		logic signed [CRD_W-1:0] p0x;
		logic signed [CRD_W-1:0] p0y;
		logic signed [CRD_W-1:0] p1x;
		logic signed [CRD_W-1:0] p1y;
		logic signed [CRD_W:0]   d01x;
		logic signed [CRD_W:0]   d01y;
		logic signed [CRD_W:0]   d12x;
		logic signed [CRD_W:0]   d12y;
	} pt_req_t;

endpackage

### hw/rtl/bzr_seq.sv
// Curve latch and point sequencer: clamps the count, looks up the step, walks t.
`timescale 1ns / 1ps
module bzr_seq
	import bzr_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [CRD_W-1:0] start_x,
	input  logic signed [CRD_W-1:0] start_y,
	input  logic signed [CRD_W-1:0] ctrl_x,
	input  logic signed [CRD_W-1:0] ctrl_y,
	input  logic signed [CRD_W-1:0] end_x,
	input  logic signed [CRD_W-1:0] end_y,
	input  logic [CNT_W-1:0]        point_count,
	output logic                    req_valid,
	input  logic                    req_ready,
	output pt_req_t                 req
);

	seq_state_t              state_q, state_nx;
	logic signed [CRD_W-1:0] p0x_q, p0y_q, p1x_q, p1y_q;
	logic signed [CRD_W:0]   d01x_q, d01y_q, d12x_q, d12y_q;
	logic [T_W-1:0]          step_q;
	logic [T_W-1:0]          t_q;
	logic [IDX_W-1:0]        idx_q;
	logic [IDX_W-1:0]        nm1_q;
	logic [IDX_W-1:0]        nm1;
	logic [T_W-1:0]          step_tbl [MAX_POINTS];
	logic                    take;
	logic                    issue;
	logic                    is_last;

	// floor(2^16 / k), worked out at elaboration
	assign step_tbl[0] = '0;
	for (genvar k = 1; k < MAX_POINTS; k++) begin : g_step
		localparam int unsigned StepVal = 65536 / k;
		assign step_tbl[k] = T_W'(StepVal);
	end

	always_comb begin
		if (point_count < CNT_W'(2)) begin
			nm1 = IDX_W'(1);
		end else if (point_count > CNT_W'(MAX_POINTS)) begin
			nm1 = IDX_W'(MAX_POINTS - 1);
		end else begin
			nm1 = IDX_W'(point_count - CNT_W'(1));
		end
	end

	assign in_ready  = (state_q == SEQ_IDLE);
	assign take      = in_valid && in_ready;
	assign req_valid = (state_q == SEQ_RUN);
	assign issue     = req_valid && req_ready;
	assign is_last   = (idx_q == nm1_q);

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			SEQ_IDLE: if (take) state_nx = SEQ_RUN;
			SEQ_RUN:  if (issue && is_last) state_nx = SEQ_IDLE;
			default:  state_nx = SEQ_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
			t_q     <= '0;
			idx_q   <= '0;
			nm1_q   <= '0;
			step_q  <= '0;
		end else begin
			state_q <= state_nx;
			if (take) begin
				t_q    <= '0;
				idx_q  <= '0;
				nm1_q  <= nm1;
				step_q <= step_tbl[nm1];
			end else if (issue) begin
				t_q   <= t_q + step_q;
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			p0x_q  <= start_x;
			p0y_q  <= start_y;
			p1x_q  <= ctrl_x;
			p1y_q  <= ctrl_y;
			d01x_q <= (CRD_W+1)'(ctrl_x) - (CRD_W+1)'(start_x);
			d01y_q <= (CRD_W+1)'(ctrl_y) - (CRD_W+1)'(start_y);
			d12x_q <= (CRD_W+1)'(end_x) - (CRD_W+1)'(ctrl_x);
			d12y_q <= (CRD_W+1)'(end_y) - (CRD_W+1)'(ctrl_y);
		end
	end

	always_comb begin
		req.t    = t_q;
		req.idx  = idx_q;
		req.last = is_last;
		req.p0x  = p0x_q;
		req.p0y  = p0y_q;
		req.p1x  = p1x_q;
		req.p1y  = p1y_q;
		req.d01x = d01x_q;
		req.d01y = d01y_q;
		req.d12x = d12x_q;
		req.d12y = d12y_q;
	end

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (state_q == SEQ_RUN) && (idx_q == '0) && (t_q == '0))
		else $error("run did not start at index zero");

	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		issue && is_last |=> state_q == SEQ_IDLE)
		else $error("run did not end after last point");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == SEQ_RUN |-> idx_q <= nm1_q && nm1_q != '0)
		else $error("point index beyond run length");

endmodule

### hw/rtl/bzr_pipe.sv
// Four-stage de Casteljau datapath with per-stage valid and back-pressure.
`timescale 1ns / 1ps
module bzr_pipe
	import bzr_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  pt_req_t                 req,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [CRD_W-1:0] point_x,
	output logic signed [CRD_W-1:0] point_y,
	output logic [IDX_W-1:0]        point_index,
	output logic                    last_point
);

	localparam int PA_W = CRD_W + 1 + T_W + 1; // 35
	localparam int Q_W  = 2 * CRD_W + 1;       // 33
	localparam int DQ_W = Q_W + 1;             // 34
	localparam int PB_W = DQ_W + T_W + 1;      // 52
	localparam logic signed [PB_W-1:0] RND = PB_W'(64'sd2147483648);

	logic v1_s1, v2_s2, v3_s3, v4_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	// stage 1: first products
	logic signed [CRD_W-1:0] p0x_s1, p0y_s1, p1x_s1, p1y_s1;
	logic signed [PA_W-1:0]  a0x_s1, a0y_s1, a1x_s1, a1y_s1;
	logic [T_W-1:0]          t_s1;
	logic [IDX_W-1:0]        idx_s1;
	logic                    last_s1;
	// stage 2: Q0, Q1 in Q8.24
	logic signed [Q_W-1:0]   q0x_s2, q0y_s2, q1x_s2, q1y_s2;
	logic [T_W-1:0]          t_s2;
	logic [IDX_W-1:0]        idx_s2;
	logic                    last_s2;
	// stage 3: second products
	logic signed [Q_W-1:0]   q0x_s3, q0y_s3;
	logic signed [PB_W-1:0]  bx_s3, by_s3;
	logic [IDX_W-1:0]        idx_s3;
	logic                    last_s3;
	// stage 4: rounded point
	logic signed [CRD_W-1:0] x_s4, y_s4;
	logic [IDX_W-1:0]        idx_s4;
	logic                    last_s4;

	logic signed [T_W:0]     t1_sg, t3_sg;
	logic signed [PA_W-1:0]  sum0x, sum0y, sum1x, sum1y;
	logic signed [PB_W-1:0]  fx, fy;

	assign rdy4     = !v4_s4 || out_ready;
	assign rdy3     = !v3_s3 || rdy4;
	assign rdy2     = !v2_s2 || rdy3;
	assign rdy1     = !v1_s1 || rdy2;
	assign in_ready = rdy1;

	assign t1_sg = $signed({1'b0, req.t});
	assign t3_sg = $signed({1'b0, t_s2});

	// Q = P * 2^16 + (P' - P) * t
	assign sum0x = PA_W'($signed({p0x_s1, 16'h0000})) + a0x_s1;
	assign sum0y = PA_W'($signed({p0y_s1, 16'h0000})) + a0y_s1;
	assign sum1x = PA_W'($signed({p1x_s1, 16'h0000})) + a1x_s1;
	assign sum1y = PA_W'($signed({p1y_s1, 16'h0000})) + a1y_s1;

	// B in Q8.40 plus half an LSB of Q8.8; bits 47:32 give the rounded Q8.8 point
	assign fx = PB_W'($signed({q0x_s3, 16'h0000})) + bx_s3 + RND;
	assign fy = PB_W'($signed({q0y_s3, 16'h0000})) + by_s3 + RND;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
		end else begin
			if (rdy1) v1_s1 <= in_valid;
			if (rdy2) v2_s2 <= v1_s1;
			if (rdy3) v3_s3 <= v2_s2;
			if (rdy4) v4_s4 <= v3_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			p0x_s1  <= req.p0x;
			p0y_s1  <= req.p0y;
			p1x_s1  <= req.p1x;
			p1y_s1  <= req.p1y;
			a0x_s1  <= req.d01x * t1_sg;
			a0y_s1  <= req.d01y * t1_sg;
			a1x_s1  <= req.d12x * t1_sg;
			a1y_s1  <= req.d12y * t1_sg;
			t_s1    <= req.t;
			idx_s1  <= req.idx;
			last_s1 <= req.last;
		end
		if (rdy2 && v1_s1) begin
			q0x_s2  <= sum0x[Q_W-1:0];
			q0y_s2  <= sum0y[Q_W-1:0];
			q1x_s2  <= sum1x[Q_W-1:0];
			q1y_s2  <= sum1y[Q_W-1:0];
			t_s2    <= t_s1;
			idx_s2  <= idx_s1;
			last_s2 <= last_s1;
		end
		if (rdy3 && v2_s2) begin
			q0x_s3  <= q0x_s2;
			q0y_s3  <= q0y_s2;
			bx_s3   <= (DQ_W'(q1x_s2) - DQ_W'(q0x_s2)) * t3_sg;
			by_s3   <= (DQ_W'(q1y_s2) - DQ_W'(q0y_s2)) * t3_sg;
			idx_s3  <= idx_s2;
			last_s3 <= last_s2;
		end
		if (rdy4 && v3_s3) begin
			x_s4    <= fx[47:32];
			y_s4    <= fy[47:32];
			idx_s4  <= idx_s3;
			last_s4 <= last_s3;
		end
	end

	assign out_valid   = v4_s4;
	assign point_x     = x_s4;
	assign point_y     = y_s4;
	assign point_index = idx_s4;
	assign last_point  = last_s4;

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		v1_s1 && v2_s2 && v3_s3 && v4_s4 && !out_ready |-> !in_ready)
		else $error("request taken into a full stalled pipeline");

	a_hold_s4: assert property (@(posedge clk) disable iff (!arst_n)
		v4_s4 && !out_ready |=> v4_s4 && $stable(idx_s4) && $stable(x_s4))
		else $error("stalled point changed");

	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v1_s1 |-> in_ready)
		else $error("empty first stage not ready");

endmodule

### hw/rtl/quadratic_bezier_point_generator_top.sv
// The first point of a curve passes the sequencer registers, then stages s1 to s4.
// The point sequencer walks one curve at a time and issues one point per cycle unless
// m_tready stalls the pipeline; s_tready stays low until a curve's last point is issued.
// The four-stage datapath lets the next curve start while earlier points drain.
// Reset (arst_n low) empties the pipeline and returns the sequencer to idle.
// Top level: stream ports, curve sequencer and de Casteljau pipeline.
`timescale 1ns / 1ps
module quadratic_bezier_point_generator_top
	import bzr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// start_x, start_y, ctrl_x, ctrl_y, end_x, end_y, point_count, zero pad
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// point_x, point_y, point_index, zero pad
	output logic [OUT_W-1:0] m_tdata,
	output logic             m_tlast
);

	pt_req_t                 req;
	logic                    req_valid;
	logic                    req_ready;
	logic signed [CRD_W-1:0] point_x, point_y;
	logic [IDX_W-1:0]        point_index;

	bzr_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.start_x     ($signed(s_tdata[15:0])),
		.start_y     ($signed(s_tdata[31:16])),
		.ctrl_x      ($signed(s_tdata[47:32])),
		.ctrl_y      ($signed(s_tdata[63:48])),
		.end_x       ($signed(s_tdata[79:64])),
		.end_y       ($signed(s_tdata[95:80])),
		.point_count (s_tdata[102:96]),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req)
	);

	bzr_pipe u_pipe (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (req_valid),
		.in_ready    (req_ready),
		.req         (req),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.point_x     (point_x),
		.point_y     (point_y),
		.point_index (point_index),
		.last_point  (m_tlast)
	);

	assign m_tdata = {2'b00, point_index, point_y, point_x};

endmodule

### sim/tb_quadratic_bezier_point_generator_top.sv
// Self-checking testbench for the quadratic Bezier point generator: random curves, stalls, scoreboard.
`timescale 1ns / 1ps
module tb_quadratic_bezier_point_generator_top;
	import bzr_pkg::*;

	localparam int HOLD_CYCLES = 600;
	localparam int IDLE_LIMIT  = 5000;
	localparam int DRAIN_WAIT  = 20;
	localparam int CNT_LSB     = 6 * CRD_W;

	typedef struct {
		logic [CRD_W-1:0] x;
		logic [CRD_W-1:0] y;
		logic [IDX_W-1:0] idx;
		logic             last;
	} point_t;

	logic            clk      = 1'b0;
	logic            arst_n   = 1'b0;
	logic            s_tvalid = 1'b0;
	logic            s_tready;
	logic [IN_W-1:0] s_tdata  = '0;
	logic            m_tvalid;
	logic            m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic            m_tlast;

	logic [IN_W-1:0] curve_q[$];
	point_t          point_q[$];
	int              errors      = 0;
	int              tx_gap_max  = 0;
	int              rx_gap_max  = 0;
	int              hold_req    = 0;
	int              idle_cycles = 0;

	quadratic_bezier_point_generator_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #4 clk = ~clk;

	task automatic report(input string what);
		$display("ERROR at %0t: %s", $realtime, what);
		errors++;
	endtask

	// Three nested lerps, exact in 64 bits, then round half up from Q8.40 to Q8.8.
	function automatic logic [CRD_W-1:0] casteljau(input longint a, input longint b,
			input longint c, input longint t);
		longint q0, q1, v, r;
		q0 = a * (65536 - t) + b * t;
		q1 = b * (65536 - t) + c * t;
		v  = q0 * (65536 - t) + q1 * t;
		r  = (v + 64'sd2147483648) >>> 32;
		return r[CRD_W-1:0];
	endfunction

	task automatic predict_points(input logic [IN_W-1:0] req);
		int     n;
		longint stp, tp;
		longint c[6];
		point_t pt;
		n = int'(req[CNT_LSB +: CNT_W]);
		if (n < 2)
			n = 2;
		if (n > MAX_POINTS)
			n = MAX_POINTS;
		for (int k = 0; k < 6; k++)
			c[k] = longint'($signed(req[k*CRD_W +: CRD_W]));
		stp = 65536 / (n - 1);
		tp  = 0;
		for (int k = 0; k < n; k++) begin
			pt.x    = casteljau(c[0], c[2], c[4], tp);
			pt.y    = casteljau(c[1], c[3], c[5], tp);
			pt.idx  = k[IDX_W-1:0];
			pt.last = (k == n - 1);
			point_q.push_back(pt);
			tp = (tp + stp) & 'h1FFFF;
		end
	endtask

	function automatic logic [IN_W-1:0] pack_curve(input logic [15:0] sx, input logic [15:0] sy,
			input logic [15:0] cx, input logic [15:0] cy, input logic [15:0] ex,
			input logic [15:0] ey, input logic [6:0] n);
		return {1'b0, n, ey, ex, cy, cx, sy, sx};
	endfunction

	function automatic logic [15:0] rand_coord();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 16'h8000;
		if (r == 1)
			return 16'h7FFF;
		return 16'($urandom);
	endfunction

	// Mostly short curves, some long ones, a few outside the legal count range.
	function automatic logic [6:0] rand_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 7'($urandom_range(2, 8));
		if (r < 88)
			return 7'($urandom_range(9, 64));
		return 7'($urandom_range(0, 127));
	endfunction

	task automatic queue_random(input int cnt);
		for (int k = 0; k < cnt; k++)
			curve_q.push_back(pack_curve(rand_coord(), rand_coord(), rand_coord(),
				rand_coord(), rand_coord(), rand_coord(), rand_count()));
	endtask

	task automatic wait_drained();
		while (curve_q.size() != 0 || s_tvalid || point_q.size() != 0)
			@(posedge clk);
	endtask

	// Request driver
	always @(posedge clk or negedge arst_n) begin : p_drive
		logic            nxt_valid;
		logic [IN_W-1:0] nxt_data;
		int              tx_wait;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			tx_wait  = 0;
		end else begin
			nxt_valid = s_tvalid;
			nxt_data  = s_tdata;
			if (s_tvalid && s_tready) begin
				predict_points(s_tdata);
				nxt_valid = 1'b0;
				tx_wait   = $urandom_range(0, tx_gap_max);
			end
			if (!nxt_valid) begin
				if (tx_wait > 0)
					tx_wait--;
				else if (curve_q.size() != 0) begin
					nxt_data  = curve_q.pop_front();
					nxt_valid = 1'b1;
				end
			end
			s_tvalid <= nxt_valid;
			s_tdata  <= nxt_data;
		end
	end

	// Point monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin : p_monitor
		point_t exp_pt;
		int     rx_wait;
		int     hold_left;
		int     hold_ack;
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_wait   = 0;
			hold_left = 0;
			hold_ack  = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (point_q.size() == 0)
					report($sformatf("unexpected point x=%h y=%h idx=%0d last=%b",
						m_tdata[15:0], m_tdata[31:16], m_tdata[37:32], m_tlast));
				else begin
					exp_pt = point_q.pop_front();
					if (m_tdata[15:0] !== exp_pt.x)
						report($sformatf("idx %0d: point_x %h, want %h",
							exp_pt.idx, m_tdata[15:0], exp_pt.x));
					if (m_tdata[31:16] !== exp_pt.y)
						report($sformatf("idx %0d: point_y %h, want %h",
							exp_pt.idx, m_tdata[31:16], exp_pt.y));
					if (m_tdata[32 +: IDX_W] !== exp_pt.idx)
						report($sformatf("point_index %0d, want %0d",
							m_tdata[32 +: IDX_W], exp_pt.idx));
					if (m_tlast !== exp_pt.last)
						report($sformatf("idx %0d: last %b, want %b",
							exp_pt.idx, m_tlast, exp_pt.last));
				end
				rx_wait = $urandom_range(0, rx_gap_max);
			end
			if (hold_req != hold_ack) begin
				hold_ack  = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (rx_wait > 0) begin
				rx_wait--;
				m_tready <= 1'b0;
			end else
				m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no request or point moved for %0d cycles", IDLE_LIMIT);
				$display("quadratic_bezier_point_generator_top: mismatch");
				$finish;
			end else
				idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: count clamping, coordinate extremes, degenerate curves
		tx_gap_max = 4;
		rx_gap_max = 4;
		curve_q.push_back(pack_curve(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 7'd2));
		curve_q.push_back(pack_curve(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 7'd0));
		curve_q.push_back(pack_curve(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 7'd1));
		curve_q.push_back(pack_curve(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 7'd3));
		curve_q.push_back(pack_curve(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 7'd64));
		curve_q.push_back(pack_curve(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 7'd65));
		curve_q.push_back(pack_curve(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 7'd127));
		curve_q.push_back(pack_curve(16'hFFFF, 16'h0001, 16'h0001, 16'hFFFF, 16'hFFFF, 16'h0001, 7'd7));
		curve_q.push_back(pack_curve(16'h0100, 16'hFF00, 16'h5555, 16'hAAAA, 16'h0000, 16'h0000, 7'd4));
		curve_q.push_back(pack_curve(16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 16'h7FFF, 16'h8000, 7'd5));
		curve_q.push_back(pack_curve(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 16'h0F0F, 16'hF0F0, 7'd63));
		curve_q.push_back(pack_curve(16'h7FFF, 16'h0000, 16'h8000, 16'h0000, 16'h7FFF, 16'h0000, 7'd100));
		curve_q.push_back(pack_curve(16'h0000, 16'h8000, 16'h0000, 16'h7FFF, 16'h0000, 16'h8000, 7'd6));
		curve_q.push_back(pack_curve(16'h0001, 16'h0002, 16'h0003, 16'h0004, 16'h0005, 16'h0006, 7'd2));
		wait_drained();

		tx_gap_max = 16;
		rx_gap_max = 16;
		queue_random(110);
		wait_drained();

		// Receiver stalls long while requests keep coming; input must back up
		tx_gap_max = 0;
		rx_gap_max = 0;
		hold_req++;
		queue_random(60);
		wait_drained();

		tx_gap_max = 0;
		rx_gap_max = 16;
		queue_random(110);
		wait_drained();

		tx_gap_max = 16;
		rx_gap_max = 0;
		queue_random(110);
		wait_drained();

		tx_gap_max = 0;
		rx_gap_max = 0;
		queue_random(50);
		tx_gap_max = 3;
		rx_gap_max = 3;
		queue_random(40);
		wait_drained();

		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0)
			$display("quadratic_bezier_point_generator_top: match");
		else
			$display("quadratic_bezier_point_generator_top: mismatch");
		$finish;
	end

endmodule

### files.f
hw/rtl/bzr_pkg.sv
hw/rtl/bzr_seq.sv
hw/rtl/bzr_pipe.sv
hw/rtl/quadratic_bezier_point_generator_top.sv
sim/tb_quadratic_bezier_point_generator_top.sv
